>>> src/mcsf_pkg.sv
package mcsf_pkg;

  // request codes
  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  // span slot within one pass, in emission order
  localparam logic [1:0] PH_ROW_UP = 2'd0;  // row cy+y, half-width x
  localparam logic [1:0] PH_ROW_DN = 2'd1;  // row cy-y, half-width x
  localparam logic [1:0] PH_COL_UP = 2'd2;  // row cy+x, half-width y
  localparam logic [1:0] PH_COL_DN = 2'd3;  // row cy-x, half-width y

  // outcome of one accepted request, walker to span sequencer
  typedef struct packed {
    logic emit;  // request produces a pass of four spans
    logic fin;   // this pass is the final one of the circle
  } walk_ctl_t;

endpackage

>>> src/mcsf_if.sv
interface mcsf_in_if #(
  parameter int COORD_BITS  = 16,
  parameter int RADIUS_BITS = 12
);
  logic                         valid;
  logic                         ready;
  logic                         opcode;
  logic signed [COORD_BITS-1:0] center_x;
  logic signed [COORD_BITS-1:0] center_y;
  logic [RADIUS_BITS-1:0]       radius_in;

  modport source (output valid, output opcode, output center_x, output center_y,
                  output radius_in, input ready);
  modport sink (input valid, input opcode, input center_x, input center_y,
                input radius_in, output ready);
endinterface

interface mcsf_out_if #(
  parameter int COORD_BITS = 16
);
  logic                       valid;
  logic                       ready;
  logic signed [COORD_BITS:0] span_row;
  logic signed [COORD_BITS:0] span_left;
  logic signed [COORD_BITS:0] span_right;
  logic                       last_span;

  modport source (output valid, output span_row, output span_left, output span_right,
                  output last_span, input ready);
  modport sink (input valid, input span_row, input span_left, input span_right,
                input last_span, output ready);
endinterface

>>> src/mcsf_walk.sv
module mcsf_walk import mcsf_pkg::*; #(
  parameter int COORD_BITS  = 16,
  parameter int RADIUS_BITS = 12
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         take,
  input  logic                         opcode,
  input  logic signed [COORD_BITS-1:0] center_x,
  input  logic signed [COORD_BITS-1:0] center_y,
  input  logic [RADIUS_BITS-1:0]       radius_in,
  output walk_ctl_t                    ctl,
  output logic [RADIUS_BITS-1:0]       pass_x,
  output logic [RADIUS_BITS-1:0]       pass_y,
  output logic signed [COORD_BITS-1:0] pass_cx,
  output logic signed [COORD_BITS-1:0] pass_cy
);

  localparam int XW = RADIUS_BITS + 1;
  localparam int EW = RADIUS_BITS + 3;
  localparam int CW = EW + 2;

  logic signed [XW-1:0]         x_r, y_r;
  logic signed [EW-1:0]         err_r;
  logic signed [COORD_BITS-1:0] cx_r, cy_r;
  logic                         busy_r;

  logic signed [CW-1:0] xe, ye, ee, y1, e1, x1, e2;
  logic                 y_inc, x_dec, can_pass;

  always_comb begin
    xe    = CW'(x_r);
    ye    = CW'(y_r);
    ee    = CW'(err_r);
    y_inc = (ee <= CW'(0));
    y1    = y_inc ? ye + CW'(1) : ye;
    e1    = y_inc ? ee + (y1 <<< 1) + CW'(1) : ee;
    x_dec = (e1 > CW'(0));
    x1    = x_dec ? xe - CW'(1) : xe;
    e2    = x_dec ? e1 - ((x1 <<< 1) + CW'(1)) : e1;
    can_pass = busy_r && (xe >= ye);
    ctl.emit = (opcode == OP_STEP) && can_pass;
    ctl.fin  = (x1 < y1);
  end

  assign pass_x  = x_r[RADIUS_BITS-1:0];
  assign pass_y  = y_r[RADIUS_BITS-1:0];
  assign pass_cx = cx_r;
  assign pass_cy = cy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r    <= '0;
      y_r    <= '0;
      err_r  <= '0;
      cx_r   <= '0;
      cy_r   <= '0;
      busy_r <= 1'b0;
    end else if (take) begin
      if (opcode == OP_START) begin
        cx_r   <= center_x;
        cy_r   <= center_y;
        x_r    <= {1'b0, radius_in};
        y_r    <= '0;
        err_r  <= '0;
        busy_r <= 1'b1;
      end else if (ctl.emit) begin
        x_r    <= x1[XW-1:0];
        y_r    <= y1[XW-1:0];
        err_r  <= e2[EW-1:0];
        busy_r <= !ctl.fin;
      end else begin
        busy_r <= 1'b0;
      end
    end
  end

endmodule

>>> src/mcsf_span.sv
module mcsf_span import mcsf_pkg::*; #(
  parameter int COORD_BITS  = 16,
  parameter int RADIUS_BITS = 12
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         load,
  input  logic                         fin,
  input  logic [RADIUS_BITS-1:0]       pass_x,
  input  logic [RADIUS_BITS-1:0]       pass_y,
  input  logic signed [COORD_BITS-1:0] pass_cx,
  input  logic signed [COORD_BITS-1:0] pass_cy,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic                         slot_free,
  output logic signed [COORD_BITS:0]   span_row,
  output logic signed [COORD_BITS:0]   span_left,
  output logic signed [COORD_BITS:0]   span_right,
  output logic                         last_span
);

  localparam int SW = ((COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS) + 2;

  logic                         valid_r;
  logic [1:0]                   phase_r;
  logic                         fin_r;
  logic [RADIUS_BITS-1:0]       x_r, y_r;
  logic signed [COORD_BITS-1:0] cx_r, cy_r;

  logic signed [SW-1:0] xe, ye, cxe, cye, off, half, row_full, left_full, right_full;
  logic                 pass_done;

  assign pass_done = valid_r && out_ready && (phase_r == PH_COL_DN);
  assign slot_free = !valid_r || pass_done;

  always_comb begin
    xe  = SW'($signed({1'b0, x_r}));
    ye  = SW'($signed({1'b0, y_r}));
    cxe = SW'(cx_r);
    cye = SW'(cy_r);
    case (phase_r)
      PH_ROW_UP: off = ye;
      PH_ROW_DN: off = -ye;
      PH_COL_UP: off = xe;
      PH_COL_DN: off = -xe;
      default:   off = ye;
    endcase
    half       = (phase_r == PH_ROW_UP || phase_r == PH_ROW_DN) ? xe : ye;
    row_full   = cye + off;
    left_full  = cxe - half;
    right_full = cxe + half;
  end

  assign out_valid  = valid_r;
  assign span_row   = row_full[COORD_BITS:0];
  assign span_left  = left_full[COORD_BITS:0];
  assign span_right = right_full[COORD_BITS:0];
  assign last_span  = fin_r && (phase_r == PH_COL_DN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      phase_r <= PH_ROW_UP;
    end else if (load) begin
      valid_r <= 1'b1;
      phase_r <= PH_ROW_UP;
    end else if (valid_r && out_ready) begin
      if (phase_r == PH_COL_DN) begin
        valid_r <= 1'b0;
      end
      phase_r <= phase_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      fin_r <= fin;
      x_r   <= pass_x;
      y_r   <= pass_y;
      cx_r  <= pass_cx;
      cy_r  <= pass_cy;
    end
  end

endmodule

>>> src/midpoint_circle_span_fill_top.sv
// latency: a step request accepted at one edge shows its first span in the next cycle
// throughput: four spans per step leave the span sequencer one per cycle while out_req.ready
//   is high; a start or an empty step returns nothing
// reset: synchronous active-low rst_n clears the walk state (no circle active) and
//   empties the span sequencer
module midpoint_circle_span_fill_top import mcsf_pkg::*; #(
  parameter int COORD_BITS  = 16,
  parameter int RADIUS_BITS = 12
) (
  input logic       clk,
  input logic       rst_n,
  mcsf_in_if.sink   in_req,
  mcsf_out_if.source out_req
);

  // request handshake
  logic      take;
  logic      slot_free;
  walk_ctl_t ctl;

  // pass snapshot handed from walker to sequencer
  logic [RADIUS_BITS-1:0]       pass_x, pass_y;
  logic signed [COORD_BITS-1:0] pass_cx, pass_cy;

  // a new request is taken as soon as the sequencer is empty or hands over its last span
  assign in_req.ready = slot_free;
  assign take         = in_req.valid && slot_free;

  // octant walker: holds centre, x, y, error and busy; updates on each taken request
  mcsf_walk #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS)
  ) u_walk (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .opcode    (in_req.opcode),
    .center_x  (in_req.center_x),
    .center_y  (in_req.center_y),
    .radius_in (in_req.radius_in),
    .ctl       (ctl),
    .pass_x    (pass_x),
    .pass_y    (pass_y),
    .pass_cx   (pass_cx),
    .pass_cy   (pass_cy)
  );

  // span sequencer: latches the pre-update x, y and centre, then plays out
  // rows cy+y, cy-y, cy+x, cy-x one per cycle while out_req.ready is high
  mcsf_span #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS)
  ) u_span (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (take && ctl.emit),
    .fin        (ctl.fin),
    .pass_x     (pass_x),
    .pass_y     (pass_y),
    .pass_cx    (pass_cx),
    .pass_cy    (pass_cy),
    .out_ready  (out_req.ready),
    .out_valid  (out_req.valid),
    .slot_free  (slot_free),
    .span_row   (out_req.span_row),
    .span_left  (out_req.span_left),
    .span_right (out_req.span_right),
    .last_span  (out_req.last_span)
  );

endmodule

>>> src/mcsf_checker.sv
module mcsf_checker #(
  parameter int COORD_BITS = 16
) (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic signed [COORD_BITS:0] span_row,
  input logic signed [COORD_BITS:0] span_left,
  input logic signed [COORD_BITS:0] span_right,
  input logic                       last_span
);

  // reset empties the result side
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // with nothing pending the block must take requests
  a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("not ready while empty");

  // a span never runs backwards
  a_span_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (span_left <= span_right))
    else $error("span left end beyond right end");

  // stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(span_row) && $stable(span_left)
      && $stable(span_right) && $stable(last_span))
    else $error("stalled result changed");

endmodule

bind midpoint_circle_span_fill_top mcsf_checker #(
  .COORD_BITS (COORD_BITS)
) u_mcsf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_req.ready),
  .out_valid  (out_req.valid),
  .out_ready  (out_req.ready),
  .span_row   (out_req.span_row),
  .span_left  (out_req.span_left),
  .span_right (out_req.span_right),
  .last_span  (out_req.last_span)
);
